// ----- hw/rtl/udec_pkg.sv -----
// Package for the URL percent decoder: character codes, phase type,
// the command beat passed from front to back, and hex helpers.
// No dependencies.
package udec_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UP_A    = 8'h41;
    localparam logic [7:0] CHAR_UP_F    = 8'h46;
    localparam logic [7:0] CHAR_LO_A    = 8'h61;
    localparam logic [7:0] CHAR_LO_F    = 8'h66;
    localparam logic [7:0] HEX_TEN      = 8'd10;

    // Escape phase: idle, '%' seen, '%' plus one digit seen.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    // One classified input byte: up to three output bytes in order.
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       last;
    } udec_cmd_t;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= CHAR_ZERO && c <= CHAR_NINE) ||
                 (c >= CHAR_UP_A && c <= CHAR_UP_F) ||
                 (c >= CHAR_LO_A && c <= CHAR_LO_F);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        if (c >= CHAR_LO_A)
        begin
            t = c - CHAR_LO_A + HEX_TEN;
        end
        else if (c >= CHAR_UP_A)
        begin
            t = c - CHAR_UP_A + HEX_TEN;
        end
        else
        begin
            t = c - CHAR_ZERO;
        end
        hex_val = t[3:0];
    endfunction

endpackage

// ----- hw/rtl/udec_front.sv -----
// Front end of the URL percent decoder: tracks the escape phase and
// turns each accepted byte into a command of zero to three output bytes.
// Depends on udec_pkg.
module udec_front
    import udec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output udec_cmd_t  cmd,
    output logic       cmd_valid
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] held_reg;

    logic       c_hex;
    logic       c_pct_open;
    logic [7:0] idle_b;
    logic [1:0] idle_n;
    phase_t     idle_phase;

    assign c_hex      = is_hex(in_byte);
    assign c_pct_open = (in_byte == CHAR_PERCENT) && !in_last;

    // Byte handled from idle: a '%' that is not last opens an escape.
    always_comb
    begin
        idle_b     = (in_byte == CHAR_PLUS) ? CHAR_SPACE : in_byte;
        idle_n     = c_pct_open ? 2'd0 : 2'd1;
        idle_phase = c_pct_open ? PH_PCT : PH_IDLE;
    end

    // Next state
    always_comb
    begin
        unique case (phase_reg)
            PH_PCT:   phase_next = (c_hex && !in_last) ? PH_DIGIT : idle_phase;
            PH_DIGIT: phase_next = c_hex ? PH_IDLE : idle_phase;
            default:  phase_next = idle_phase;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd.b0   = idle_b;
        cmd.b1   = idle_b;
        cmd.b2   = idle_b;
        cmd.cnt  = idle_n;
        cmd.last = in_last;
        unique case (phase_reg)
            PH_PCT:
            begin
                if (c_hex && !in_last)
                begin
                    cmd.cnt = 2'd0;
                end
                else
                begin
                    cmd.b0  = CHAR_PERCENT;
                    cmd.cnt = 2'd1 + idle_n;
                end
            end
            PH_DIGIT:
            begin
                if (c_hex)
                begin
                    cmd.b0  = {hex_val(held_reg), hex_val(in_byte)};
                    cmd.cnt = 2'd1;
                end
                else
                begin
                    cmd.b0  = CHAR_PERCENT;
                    cmd.b1  = held_reg;
                    cmd.cnt = 2'd2 + idle_n;
                end
            end
            default:
            begin
                cmd.cnt = idle_n;
            end
        endcase
    end

    assign cmd_valid = accept && (cmd.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
        end
    end

    // Hold the first digit of a pending escape.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (accept && phase_reg == PH_PCT && c_hex && !in_last)
        begin
            held_reg <= in_byte;
        end
    end

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |=> phase_reg == PH_IDLE)
        else $error("escape left open after last byte");

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |-> cmd_valid)
        else $error("last byte produced no output");

endmodule

// ----- hw/rtl/udec_fifo.sv -----
// Command queue between front and back of the URL percent decoder.
// Depends on udec_pkg.
module udec_fifo
    import udec_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  udec_cmd_t wr_data,
    input  logic      rd_en,
    output udec_cmd_t rd_data,
    output logic      full,
    output logic      nonempty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    udec_cmd_t       mem [DEPTH];
    logic [PW-1:0]   wptr_reg;
    logic [PW-1:0]   rptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        bump = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full     = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign rd_data  = mem[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= bump(wptr_reg);
            end
            if (rd_en)
            begin
                rptr_reg <= bump(rptr_reg);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg] <= wr_data;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full) && !(rd_en && !nonempty))
        else $error("queue overrun or underrun");

endmodule

// ----- hw/rtl/udec_back.sv -----
// Back end of the URL percent decoder (depends on udec_pkg): walks
// each command into the output reg, one byte per cycle while popped.
module udec_back
    import udec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  udec_cmd_t  head,
    input  logic       head_valid,
    output logic       head_done,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic [1:0] idx_reg;
    logic       ovalid_reg;
    logic [7:0] obyte_reg;
    logic       olast_reg;
    logic       load;
    logic       at_end;
    logic [7:0] sel_byte;

    assign load      = head_valid && (!ovalid_reg || pop);
    assign at_end    = (idx_reg == head.cnt - 2'd1);
    assign head_done = load && at_end;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head.b0;
            2'd1:    sel_byte = head.b1;
            default: sel_byte = head.b2;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg <= at_end ? 2'd0 : idx_reg + 2'd1;
            end
            if (load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (pop)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            obyte_reg <= sel_byte;
            olast_reg <= head.last && at_end;
        end
    end

    assign empty    = !ovalid_reg;
    assign out_byte = obyte_reg;
    assign out_last = olast_reg;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> idx_reg < head.cnt)
        else $error("byte index past end of command");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> idx_reg == 2'd0)
        else $error("byte index not rewound with queue empty");

endmodule

// ----- hw/rtl/url_percent_decoder.sv -----
// URL percent decoder, top level. Depends on udec_pkg, udec_front,
// udec_fifo and udec_back.
// A decoded byte is queued, then loaded into the output register, where empty low shows it.
// One input beat per cycle while not full; the back end emits one output beat per cycle
// while popped, so a broken escape yielding three bytes stalls input while the queue fills.
// Reset (rst_n low, asynchronous) clears the escape phase, queue and output valid.
module url_percent_decoder
    import udec_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       out_last
);

    // Input beat is taken whenever the command queue has room, even if
    // the byte produces no output (the first two bytes of an escape).
    logic      accept;
    udec_cmd_t front_cmd;
    logic      front_valid;
    udec_cmd_t head_cmd;
    logic      head_valid;
    logic      head_done;

    assign accept = push && !full;

    // Front: classify the byte against the escape phase.
    udec_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .cmd       (front_cmd),
        .cmd_valid (front_valid)
    );

    // Queue: decouple classification from byte-by-byte emission.
    udec_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_valid),
        .wr_data  (front_cmd),
        .rd_en    (head_done),
        .rd_data  (head_cmd),
        .full     (full),
        .nonempty (head_valid)
    );

    // Back: advance through each command into the output register.
    udec_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .head_valid (head_valid),
        .head_done  (head_done),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .out_last   (out_last)
    );

endmodule

// ----- tb/tb_url_percent_decoder.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for url_percent_decoder: directed and random strings,
// predicted decoded beats checked in order. Depends on udec_pkg and the RTL only.
module tb_url_percent_decoder
    import udec_pkg::*;
();

    // One decoded beat as it leaves the block.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } dec_beat_t;

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       push     = 1'b0;
    logic [7:0] in_byte  = 8'h20;
    logic       in_last  = 1'b0;
    logic       pop      = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       out_last;

    // Decoded beats still owed by the block, oldest first.
    dec_beat_t  decoded_q[$];

    // Shadow of the decoder's escape state.
    phase_t     esc_phase;
    logic [7:0] held_digit;

    int         err_count   = 0;
    int         items_sent  = 0;
    int         beats_seen  = 0;
    bit         tx_eager    = 1'b0;  // sender never idles while set
    bit         rx_eager    = 1'b0;  // receiver never stalls while set
    int         rx_hold_req = 0;     // request a long receiver hold-off, in cycles

    url_percent_decoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .out_last (out_last)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Hard stop: far beyond the slowest correct run (every item yielding three
    // beats behind the longest receiver stall, every sender gap at its longest).
    initial
    begin
        #10_000_000;
        $display("tb_url_percent_decoder failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Return {valid, value} for one hex digit in either letter case.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            d = c - CHAR_ZERO;
            return {1'b1, d[3:0]};
        end
        if (c >= CHAR_UP_A && c <= CHAR_UP_F)
        begin
            d = c - CHAR_UP_A + HEX_TEN;
            return {1'b1, d[3:0]};
        end
        if (c >= CHAR_LO_A && c <= CHAR_LO_F)
        begin
            d = c - CHAR_LO_A + HEX_TEN;
            return {1'b1, d[3:0]};
        end
        return 5'b0_0000;
    endfunction

    task automatic owe_beat(input logic [7:0] data, input logic last);
        decoded_q.push_back('{data: data, last: last});
    endtask

    // Decode one byte with no escape pending.
    task automatic decode_plain(input logic [7:0] c, input logic last);
        esc_phase = PH_IDLE;
        if (c == CHAR_PERCENT)
        begin
            // A lone '%' on the final byte cannot open an escape.
            if (last)
                owe_beat(CHAR_PERCENT, 1'b1);
            else
                esc_phase = PH_PCT;
        end
        else if (c == CHAR_PLUS)
        begin
            owe_beat(CHAR_SPACE, last);
        end
        else
        begin
            owe_beat(c, last);
        end
    endtask

    // Advance the shadow state by one accepted input beat.
    task automatic decode_byte(input logic [7:0] c, input logic last);
        logic [4:0] nib;
        logic [4:0] hnib;
        nib  = nibble_of(c);
        hnib = nibble_of(held_digit);
        case (esc_phase)
            PH_PCT:
            begin
                if (nib[4] && !last)
                begin
                    held_digit = c;
                    esc_phase  = PH_DIGIT;
                end
                else
                begin
                    // Broken or cut-off escape: give back the '%' and restart.
                    owe_beat(CHAR_PERCENT, 1'b0);
                    decode_plain(c, last);
                end
            end
            PH_DIGIT:
            begin
                if (nib[4])
                begin
                    owe_beat({hnib[3:0], nib[3:0]}, last);
                    esc_phase = PH_IDLE;
                end
                else
                begin
                    owe_beat(CHAR_PERCENT, 1'b0);
                    owe_beat(held_digit, 1'b0);
                    decode_plain(c, last);
                end
            end
            default:
            begin
                decode_plain(c, last);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Offer one beat, hold it until accepted, then idle for a random gap.
    task automatic send_item(input logic [7:0] b, input logic last);
        int gap;
        push    <= 1'b1;
        in_byte <= b;
        in_last <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        decode_byte(b, last);
        items_sent++;
        gap = tx_eager ? 0 : pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s, input bit ends_string);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], ends_string && (i == s.len() - 1));
    endtask

    // Stop offering and wait for every owed beat to come out.
    task automatic wait_drained();
        push <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    initial
    begin
        int        stall_left;
        int        hold_left;
        dec_beat_t want;
        int        r;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                beats_seen++;
                if (decoded_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat byte=%02h last=%0b",
                                              out_byte, out_last));
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_byte !== want.data)
                        report_mismatch($sformatf("beat %0d: byte %02h, want %02h",
                                                  beats_seen, out_byte, want.data));
                    if (out_last !== want.last)
                        report_mismatch($sformatf("beat %0d: last %0b, want %0b",
                                                  beats_seen, out_last, want.last));
                end
            end
            // Pick pop for the next edge: a requested hold-off wins over everything.
            if (rx_hold_req > 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (rx_eager)
            begin
                stall_left = 0;
                pop <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    pop <= 1'b1;
                else
                begin
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                    pop <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Bytes 01 and FF near the ends of the byte range, bytes above 127, and '+' on the final byte.
    task automatic test_plain_bytes();
        send_item(8'h01, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(CHAR_PLUS, 1'b1);
    endtask

    // Well-formed escapes: lowest and highest result, both letter cases.
    task automatic test_escapes();
        send_text("%00", 1'b0);
        send_text("%fF", 1'b0);
        send_text("%9A", 1'b1);
    endtask

    // Broken second and third characters, and escapes cut off by the end.
    task automatic test_broken_escapes();
        send_text("%G", 1'b0);   // non-hex after '%'
        send_text("%+", 1'b0);   // '+' after '%' still becomes a space
        send_text("%4G", 1'b0);  // three beats from one byte
        send_text("%a%", 1'b1);  // new '%' on the final byte after a digit
        send_text("%", 1'b1);    // lone '%' ends the string
        send_text("%A", 1'b1);   // hex digit on the final byte cannot complete the escape
    endtask

    function automatic logic [7:0] rand_hex_char();
        logic [3:0] v;
        v = 4'($urandom_range(0, 15));
        if (v < 4'd10)
            return CHAR_ZERO + {4'd0, v};
        return ($urandom_range(0, 1) ? CHAR_LO_A : CHAR_UP_A) + {4'd0, v} - HEX_TEN;
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        logic [4:0] nib;
        do
        begin
            c   = 8'($urandom_range(1, 255));
            nib = nibble_of(c);
        end
        while (nib[4]);
        return c;
    endfunction

    // Build one string of random tokens, mostly well formed, and send it.
    task automatic send_random_string();
        logic [7:0] text[$];
        int         ntok;
        int         r;
        ntok = $urandom_range(1, 6);
        for (int t = 0; t < ntok; t++)
        begin
            r = $urandom_range(0, 99);
            if (r < 42)
                text.push_back(8'($urandom_range(8'h21, 8'h7E)));
            else if (r < 52)
                text.push_back(CHAR_PLUS);
            else if (r < 80)
            begin
                text.push_back(CHAR_PERCENT);
                text.push_back(rand_hex_char());
                text.push_back(rand_hex_char());
            end
            else if (r < 87)
            begin
                text.push_back(CHAR_PERCENT);
                text.push_back(rand_non_hex());
            end
            else if (r < 94)
            begin
                text.push_back(CHAR_PERCENT);
                text.push_back(rand_hex_char());
                text.push_back(rand_non_hex());
            end
            else
                text.push_back(8'($urandom_range(1, 255)));
        end
        // Now and then cut an escape off at the end of the string.
        if ($urandom_range(0, 9) == 0)
        begin
            text.push_back(CHAR_PERCENT);
            if ($urandom_range(0, 1))
                text.push_back(rand_hex_char());
        end
        foreach (text[i])
            send_item(text[i], i == text.size() - 1);
    endtask

    task automatic test_random_strings(input int target);
        int stop_at;
        stop_at = items_sent + target;
        while (items_sent < stop_at)
        begin
            // Every so often run a stretch with no idling on either side.
            tx_eager = ($urandom_range(0, 7) == 0);
            rx_eager = tx_eager;
            send_random_string();
        end
        tx_eager = 1'b0;
        rx_eager = 1'b0;
    endtask

    // Hold the receiver off while the sender keeps offering three-beat
    // escapes, so the queue fills and full stalls the input.
    task automatic test_backpressure();
        tx_eager    = 1'b1;
        rx_hold_req = 80;
        for (int i = 0; i < 8; i++)
            send_text("%7Z", i == 7);
        tx_eager = 1'b0;
        wait_drained();
    endtask

    // Pause the sender between strings until everything has come out.
    task automatic test_drain_pause();
        send_text("a+%41", 1'b1);
        wait_drained();
        send_text("%2b%", 1'b1);
        wait_drained();
    endtask

    initial
    begin
        int waited;
        // Hold reset low from time zero, then release on a clock edge.
        repeat (12) @(posedge clk);
        rst_n      <= 1'b1;
        esc_phase   = PH_IDLE;
        held_digit  = 8'h00;

        test_plain_bytes();
        test_escapes();
        test_broken_escapes();
        test_backpressure();
        test_drain_pause();
        test_random_strings(300);

        // Let the last beats drain, then wait on for any stray beats.
        wait_drained_bounded: begin
            push  <= 1'b0;
            waited = 0;
            while (decoded_q.size() != 0 && waited < 20000)
            begin
                @(posedge clk);
                waited++;
            end
        end
        repeat (8) @(posedge clk);
        if (decoded_q.size() != 0)
            report_mismatch($sformatf("%0d decoded beats never arrived", decoded_q.size()));

        if (err_count == 0)
            $display("tb_url_percent_decoder passed");
        else
            $display("tb_url_percent_decoder failed");
        $finish;
    end

endmodule
